>>> src/mab_pkg.sv
// Package: shared types and codes for the MP3 ADU segment builder.
package mab_pkg;

    localparam logic [2:0] KIND_PH  = 3'd0;
    localparam logic [2:0] KIND_IH  = 3'd1;
    localparam logic [2:0] KIND_HC  = 3'd2;
    localparam logic [2:0] KIND_DB  = 3'd3;
    localparam logic [2:0] KIND_ERR = 3'd4;

    localparam logic CFG_IL_EN = 1'b0;
    localparam logic CFG_SPG   = 1'b1;

    typedef struct packed {
        logic [31:0] hdr;
        logic [8:0]  bp;
        logic [5:0]  side;
        logic [11:0] size;
    } row_t;

    typedef struct packed {
        logic       clear;
        logic       load_wr;
        logic       start_build;
        logic       cap_s;
        logic       cap_n;
        logic       walk_step;
        logic       walk_cap;
        logic       walk_fix;
        logic       gather_step;
        logic       out_ld;
        logic [2:0] out_kind;
        logic       out_last;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic in_build;
        logic in_s_zero;
        logic walk_cover;
        logic walk_fail;
        logic div_done;
        logic slot_free;
        logic il_en;
        logic hc_last;
        logic db_last;
    } dp_stat_t;

endpackage

>>> src/mab_if.sv
// Interfaces: input and result word channels.
interface mab_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [11:0] frame_index;
    logic [11:0] frame_bytes;
    logic [5:0]  side_info_bytes;
    logic [8:0]  back_pointer;
    logic [31:0] frame_header;

    modport source (output valid, cmd, frame_index, frame_bytes, side_info_bytes,
                    back_pointer, frame_header, input ready);
    modport sink   (input valid, cmd, frame_index, frame_bytes, side_info_bytes,
                    back_pointer, frame_header, output ready);
endinterface

interface mab_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] header_word;
    logic [11:0] source_frame;
    logic [11:0] byte_offset;
    logic [11:0] byte_count;
    logic        last;

    modport source (output valid, kind, header_word, source_frame, byte_offset,
                    byte_count, last, input ready);
    modport sink   (input valid, kind, header_word, source_frame, byte_offset,
                    byte_count, last, output ready);
endinterface

>>> src/mab_ctrl.sv
// Controller: sequences clear, load, walk, divide and result emission.
module mab_ctrl
    import mab_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_RD_S  = 4'd2;
    localparam logic [3:0] ST_RD_N  = 4'd3;
    localparam logic [3:0] ST_WCHK  = 4'd4;
    localparam logic [3:0] ST_WRD   = 4'd5;
    localparam logic [3:0] ST_DIVW  = 4'd6;
    localparam logic [3:0] ST_E_PH  = 4'd7;
    localparam logic [3:0] ST_E_IH  = 4'd8;
    localparam logic [3:0] ST_E_HC  = 4'd9;
    localparam logic [3:0] ST_E_DB  = 4'd10;
    localparam logic [3:0] ST_E_ERR = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       acc;

    assign in_ready = (state_reg == ST_IDLE);
    assign acc      = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (acc && !stat.in_build)
                begin
                    cmd.load_wr = 1'b1;
                end
                else if (acc)
                begin
                    cmd.start_build = 1'b1;
                    state_next = stat.in_s_zero ? ST_E_ERR : ST_RD_S;
                end
            end
            ST_RD_S:
            begin
                cmd.cap_s  = 1'b1;
                state_next = ST_RD_N;
            end
            ST_RD_N:
            begin
                cmd.cap_n  = 1'b1;
                state_next = ST_WCHK;
            end
            ST_WCHK:
            begin
                if (stat.walk_cover)
                begin
                    cmd.walk_fix = 1'b1;
                    state_next   = ST_DIVW;
                end
                else if (stat.walk_fail)
                begin
                    state_next = ST_E_ERR;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                    state_next    = ST_WRD;
                end
            end
            ST_WRD:
            begin
                cmd.walk_cap = 1'b1;
                state_next   = ST_WCHK;
            end
            ST_DIVW:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_E_PH;
                end
            end
            ST_E_PH:
            begin
                cmd.out_kind = KIND_PH;
                if (stat.slot_free)
                begin
                    cmd.out_ld = 1'b1;
                    state_next = stat.il_en ? ST_E_IH : ST_E_HC;
                end
            end
            ST_E_IH:
            begin
                cmd.out_kind = KIND_IH;
                if (stat.slot_free)
                begin
                    cmd.out_ld = 1'b1;
                    state_next = ST_E_HC;
                end
            end
            ST_E_HC:
            begin
                cmd.out_kind = KIND_HC;
                cmd.out_last = stat.hc_last;
                if (stat.slot_free)
                begin
                    cmd.out_ld = 1'b1;
                    state_next = stat.hc_last ? ST_IDLE : ST_E_DB;
                end
            end
            ST_E_DB:
            begin
                cmd.out_kind = KIND_DB;
                cmd.out_last = stat.db_last;
                if (stat.slot_free)
                begin
                    cmd.out_ld      = 1'b1;
                    cmd.gather_step = 1'b1;
                    if (stat.db_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_E_ERR:
            begin
                cmd.out_kind = KIND_ERR;
                cmd.out_last = 1'b1;
                if (stat.slot_free)
                begin
                    cmd.out_ld = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/mab_dp.sv
// Datapath: frame table, walk registers, group divider and result register.
module mab_dp
    import mab_pkg::*;
#(
    parameter int TABLE_DEPTH     = 4096,
    parameter int MAX_BACK_FRAMES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_cmd,
    input  logic [11:0] in_frame_index,
    input  logic [11:0] in_frame_bytes,
    input  logic [5:0]  in_side_info_bytes,
    input  logic [8:0]  in_back_pointer,
    input  logic [31:0] in_frame_header,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [2:0]  out_kind,
    output logic [31:0] out_header_word,
    output logic [11:0] out_source_frame,
    output logic [11:0] out_byte_offset,
    output logic [11:0] out_byte_count,
    output logic        out_last,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int IW = $clog2(MAX_BACK_FRAMES);

    function automatic logic in_tab(input logic [12:0] v);
        return {19'd0, v} < 32'(TABLE_DEPTH);
    endfunction

    row_t mem [TABLE_DEPTH];
    row_t rd_row_reg;
    logic rd_oor_reg;
    row_t rd;

    logic [AW-1:0] clr_cnt_reg;
    logic          il_en_reg;
    logic [7:0]    spg_reg;

    logic [11:0] s_reg;
    logic [11:0] sid_reg;
    logic [8:0]  bp_reg;
    logic [11:0] size_s_reg;
    logic [5:0]  side_s_reg;
    logic [31:0] hdr_s_reg;
    logic [15:0] prev_reg;
    logic [IW-1:0] nm1_reg;
    logic [12:0] offs_reg [MAX_BACK_FRAMES];
    logic [11:0] sizes_reg [MAX_BACK_FRAMES];
    logic [12:0] adu_reg;
    logic [12:0] adu_data_reg;
    logic [IW-1:0] gi_reg;
    logic [12:0] done_reg;

    logic [11:0] num_reg;
    logic [7:0]  rem_reg;
    logic [3:0]  dcnt_reg;
    logic        dbusy_reg;

    logic        ov_reg;
    logic [2:0]  okind_reg;
    logic [31:0] ohw_reg;
    logic [11:0] osrc_reg;
    logic [11:0] ooff_reg;
    logic [11:0] ocnt_reg;
    logic        olast_reg;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    row_t          wr_row;
    logic [AW-1:0] rd_addr;
    logic          rd_oor_next;
    logic [12:0]   rd_idx;
    logic [6:0]    rd_hb;
    logic [11:0]   rd_db;
    logic [13:0]   adu_sum;
    logic [12:0]   hs;
    logic [15:0]   adj;
    logic [12:0]   grem;
    logic [12:0]   blk;
    logic [7:0]    g;
    logic [8:0]    dsh;

    // table port
    assign wr_en   = cmd.clear || (cmd.load_wr && in_tab({1'b0, in_frame_index}));
    assign wr_addr = cmd.clear ? clr_cnt_reg : AW'(in_frame_index);
    assign wr_row  = cmd.clear ? row_t'('0)
                   : row_t'{hdr: in_frame_header, bp: in_back_pointer,
                            side: in_side_info_bytes, size: in_frame_bytes};

    always_comb
    begin
        rd_idx = '0;
        if (cmd.start_build)
        begin
            rd_idx = {1'b0, in_frame_index};
        end
        else if (cmd.cap_s)
        begin
            rd_idx = {1'b0, s_reg} + 13'd1;
        end
        else if (cmd.walk_step)
        begin
            rd_idx = {1'b0, sid_reg - 12'd1};
        end
    end

    assign rd_addr     = AW'(rd_idx);
    assign rd_oor_next = !in_tab(rd_idx);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_row;
        end
        rd_row_reg <= mem[rd_addr];
        rd_oor_reg <= rd_oor_next;
    end

    assign rd    = rd_oor_reg ? row_t'('0) : rd_row_reg;
    assign rd_hb = 7'd4 + {1'b0, rd.side};
    assign rd_db = (rd.size > {5'd0, rd_hb}) ? rd.size - {5'd0, rd_hb} : 12'd0;

    assign adu_sum = {5'd0, bp_reg} + {2'd0, size_s_reg};
    assign hs      = 13'd4 + {7'd0, side_s_reg};
    assign adj     = prev_reg - {7'd0, bp_reg};
    assign grem    = adu_data_reg - done_reg;
    assign blk     = ({1'b0, sizes_reg[gi_reg]} < grem) ? {1'b0, sizes_reg[gi_reg]} : grem;
    assign g       = (spg_reg == 8'd0) ? 8'd1 : spg_reg;
    assign dsh     = {rem_reg, num_reg[11]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            il_en_reg   <= 1'b0;
            spg_reg     <= 8'd1;
            dbusy_reg   <= 1'b0;
            dcnt_reg    <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cfg_we && cfg_index == CFG_IL_EN)
            begin
                il_en_reg <= cfg_data[0];
            end
            if (cfg_we && cfg_index == CFG_SPG)
            begin
                spg_reg <= cfg_data;
            end
            if (cmd.cap_s)
            begin
                dbusy_reg <= 1'b1;
                dcnt_reg  <= 4'd11;
            end
            else if (dbusy_reg)
            begin
                dcnt_reg <= dcnt_reg - 4'd1;
                if (dcnt_reg == 4'd0)
                begin
                    dbusy_reg <= 1'b0;
                end
            end
            if (cmd.out_ld)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_build)
        begin
            s_reg <= in_frame_index;
        end
        if (cmd.cap_s)
        begin
            bp_reg       <= rd.bp;
            size_s_reg   <= rd.size;
            side_s_reg   <= rd.side;
            hdr_s_reg    <= rd.hdr;
            offs_reg[0]  <= {6'd0, rd_hb};
            sizes_reg[0] <= rd_db;
            prev_reg     <= '0;
            nm1_reg      <= '0;
            sid_reg      <= s_reg;
            num_reg      <= s_reg - 12'd1;
            rem_reg      <= '0;
        end
        else if (dbusy_reg)
        begin
            if (dsh >= {1'b0, g})
            begin
                rem_reg <= 8'(dsh - {1'b0, g});
                num_reg <= {num_reg[10:0], 1'b1};
            end
            else
            begin
                rem_reg <= dsh[7:0];
                num_reg <= {num_reg[10:0], 1'b0};
            end
        end
        if (cmd.cap_n)
        begin
            adu_reg <= (adu_sum > {5'd0, rd.bp}) ? 13'(adu_sum - {5'd0, rd.bp}) : 13'd0;
        end
        if (cmd.walk_step)
        begin
            sid_reg <= sid_reg - 12'd1;
            nm1_reg <= nm1_reg + IW'(1);
        end
        if (cmd.walk_cap)
        begin
            offs_reg[nm1_reg]  <= {6'd0, rd_hb};
            sizes_reg[nm1_reg] <= rd_db;
            prev_reg           <= prev_reg + {4'd0, rd_db};
        end
        if (cmd.walk_fix)
        begin
            offs_reg[nm1_reg]  <= offs_reg[nm1_reg] + 13'(adj);
            sizes_reg[nm1_reg] <= sizes_reg[nm1_reg] - 12'(adj);
            gi_reg             <= nm1_reg;
            done_reg           <= '0;
            adu_data_reg       <= (adu_reg > hs) ? adu_reg - hs : 13'd0;
        end
        if (cmd.gather_step)
        begin
            done_reg <= done_reg + blk;
            gi_reg   <= gi_reg - IW'(1);
        end
        if (cmd.out_ld)
        begin
            okind_reg <= cmd.out_kind;
            olast_reg <= cmd.out_last;
            case (cmd.out_kind)
                KIND_PH:
                begin
                    ohw_reg  <= {16'd0, 3'b010, adu_reg};
                    osrc_reg <= '0;
                    ooff_reg <= '0;
                    ocnt_reg <= '0;
                end
                KIND_IH:
                begin
                    ohw_reg  <= {rem_reg, num_reg[2:0], hdr_s_reg[20:0]};
                    osrc_reg <= '0;
                    ooff_reg <= '0;
                    ocnt_reg <= '0;
                end
                KIND_HC:
                begin
                    ohw_reg  <= '0;
                    osrc_reg <= s_reg;
                    ooff_reg <= il_en_reg ? 12'd4 : 12'd0;
                    ocnt_reg <= il_en_reg ? {6'd0, side_s_reg} : hs[11:0];
                end
                KIND_DB:
                begin
                    ohw_reg  <= '0;
                    osrc_reg <= s_reg - {{(12-IW){1'b0}}, gi_reg};
                    ooff_reg <= offs_reg[gi_reg][11:0];
                    ocnt_reg <= blk[11:0];
                end
                default:
                begin
                    ohw_reg  <= '0;
                    osrc_reg <= s_reg;
                    ooff_reg <= '0;
                    ocnt_reg <= '0;
                end
            endcase
        end
    end

    assign stat.clear_last = (clr_cnt_reg == AW'(TABLE_DEPTH - 1));
    assign stat.in_build   = in_cmd;
    assign stat.in_s_zero  = (in_frame_index == 12'd0);
    assign stat.walk_cover = (prev_reg >= {7'd0, bp_reg});
    assign stat.walk_fail  = (sid_reg == 12'd1) || (nm1_reg == IW'(MAX_BACK_FRAMES - 1));
    assign stat.div_done   = !dbusy_reg;
    assign stat.slot_free  = !ov_reg || out_ready;
    assign stat.il_en      = il_en_reg;
    assign stat.hc_last    = (adu_data_reg == 13'd0);
    assign stat.db_last    = (gi_reg == '0) || (blk == grem);

    assign out_valid        = ov_reg;
    assign out_kind         = okind_reg;
    assign out_header_word  = ohw_reg;
    assign out_source_frame = osrc_reg;
    assign out_byte_offset  = ooff_reg;
    assign out_byte_count   = ocnt_reg;
    assign out_last         = olast_reg;

endmodule

>>> src/mp3_adu_segment_builder_top.sv
// Top level: MP3 ADU segment builder.
//   channel  dir  word
//   in_ch    in   cmd, frame_index, frame_bytes, side_info_bytes, back_pointer, frame_header
//   out_ch   out  kind, header_word, source_frame, byte_offset, byte_count, last
//   cfg      in   cfg_we, cfg_index, cfg_data (no read-back)
// A load writes its table row and leaves in_ch.ready high. A build walks back
// through the table while the 12-step group divider runs, and loads its first
// result word once both are done; a failed walk or frame 0 gives an error word.
// After reset the frame table is cleared row by row, from first to last; in_ch.ready is
// low meanwhile. One command in flight; the result register stalls on out_ch.ready.
module mp3_adu_segment_builder_top
    import mab_pkg::*;
#(
    parameter int TABLE_DEPTH     = 4096,
    parameter int MAX_BACK_FRAMES = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    mab_in_if.sink     in_ch,
    mab_out_if.source  out_ch
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    mab_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mab_dp #(
        .TABLE_DEPTH     (TABLE_DEPTH),
        .MAX_BACK_FRAMES (MAX_BACK_FRAMES)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_cmd             (in_ch.cmd),
        .in_frame_index     (in_ch.frame_index),
        .in_frame_bytes     (in_ch.frame_bytes),
        .in_side_info_bytes (in_ch.side_info_bytes),
        .in_back_pointer    (in_ch.back_pointer),
        .in_frame_header    (in_ch.frame_header),
        .out_ready          (out_ch.ready),
        .out_valid          (out_ch.valid),
        .out_kind           (out_ch.kind),
        .out_header_word    (out_ch.header_word),
        .out_source_frame   (out_ch.source_frame),
        .out_byte_offset    (out_ch.byte_offset),
        .out_byte_count     (out_ch.byte_count),
        .out_last           (out_ch.last),
        .cmd                (cmd),
        .stat               (stat)
    );

endmodule

>>> tb/mp3_adu_segment_builder_top_tb.sv
// Testbench: frame-table loads and ADU descriptor builds checked against a built-in predictor.
module mp3_adu_segment_builder_top_tb;
    import mab_pkg::*;

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] header_word;
        logic [11:0] source_frame;
        logic [11:0] byte_offset;
        logic [11:0] byte_count;
        logic        last;
    } seg_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_index = CFG_IL_EN;
    logic [7:0] cfg_data = 8'd0;

    mab_in_if  in_ch();
    mab_out_if out_ch();

    mp3_adu_segment_builder_top uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source)
    );

    always #5 clk = ~clk;

    // frame table copy
    logic [11:0] size_tab [4096];
    logic [5:0]  side_tab [4096];
    logic [8:0]  bp_tab   [4096];
    logic [31:0] hdr_tab  [4096];
    bit          loaded   [4096];
    logic        il_en = 1'b0;
    logic [7:0]  group_size = 8'd1;

    seg_t seg_q[$];
    int   errors = 0;
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    int   hold_cycles = 0;
    int   quiet_cycles = 0;

    function automatic int data_len(int f);
        int h;
        h = 4 + side_tab[f];
        return (size_tab[f] > h) ? size_tab[f] - h : 0;
    endfunction

    function automatic void predict_segments(int s);
        int   offs[8];
        int   sizes[8];
        int   bp, prev, sid, n, adj, h, a, adu, adu_data, done, blk, g, k, nbp;
        bit   fail;
        seg_t res[11];
        logic [7:0]  idx;
        logic [2:0]  cyc;
        logic [31:0] fh;
        k = 0;
        fail = 0;
        if (s == 0)
            fail = 1;
        else
        begin
            bp = bp_tab[s];
            sid = s;
            n = 1;
            prev = 0;
            offs[0] = 4 + side_tab[s];
            sizes[0] = data_len(s);
            while (1)
            begin
                if (prev >= bp)
                begin
                    adj = prev - bp;
                    offs[n-1] += adj;
                    sizes[n-1] -= adj;
                    break;
                end
                sid--;
                n++;
                if (sid == 0 || n > 8)
                begin
                    fail = 1;
                    break;
                end
                offs[n-1] = 4 + side_tab[sid];
                sizes[n-1] = data_len(sid);
                prev += sizes[n-1];
            end
        end
        if (fail)
        begin
            seg_q.push_back('{KIND_ERR, 32'd0, s[11:0], 12'd0, 12'd0, 1'b1});
            return;
        end
        h = 4 + side_tab[s];
        nbp = (s + 1 < 4096) ? bp_tab[s+1] : 0;
        a = bp + size_tab[s] - nbp;
        adu = a > 0 ? a : 0;
        adu_data = adu > h ? adu - h : 0;
        res[k++] = '{KIND_PH, 32'h4000 | (adu & 32'h3FFF), 12'd0, 12'd0, 12'd0, 1'b0};
        if (il_en)
        begin
            g = group_size == 0 ? 1 : group_size;
            idx = 8'((s - 1) % g);
            cyc = 3'(((s - 1) / g) & 7);
            fh = hdr_tab[s];
            res[k++] = '{KIND_IH, {idx, cyc, fh[20:16], fh[15:0]}, 12'd0, 12'd0, 12'd0, 1'b0};
            res[k++] = '{KIND_HC, 32'd0, s[11:0], 12'd4, {6'd0, side_tab[s]}, 1'b0};
        end
        else
            res[k++] = '{KIND_HC, 32'd0, s[11:0], 12'd0, h[11:0], 1'b0};
        done = 0;
        for (int i = n - 1; i >= 0 && done < adu_data; i--)
        begin
            blk = sizes[i];
            if (adu_data - done < blk)
                blk = adu_data - done;
            res[k++] = '{KIND_DB, 32'd0, s[11:0] - i[11:0], offs[i][11:0], blk[11:0], 1'b0};
            done += blk;
        end
        res[k-1].last = 1'b1;
        for (int i = 0; i < k; i++)
            seg_q.push_back(res[i]);
    endfunction

    // in the random test, only frames whose whole walk window is loaded get built, apart from frame 0
    function automatic bit can_build(int s);
        for (int f = (s > 8 ? s - 7 : 1); f <= s; f++)
            if (!loaded[f])
                return 0;
        return 1;
    endfunction

    task automatic send_word(bit cmd, int fi, int fb, int side, int bp, logic [31:0] hdr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.cmd             <= cmd;
        in_ch.frame_index     <= 12'(fi);
        in_ch.frame_bytes     <= 12'(fb);
        in_ch.side_info_bytes <= 6'(side);
        in_ch.back_pointer    <= 9'(bp);
        in_ch.frame_header    <= hdr;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (cmd)
            predict_segments(fi);
        else
        begin
            size_tab[fi] = 12'(fb);
            side_tab[fi] = 6'(side);
            bp_tab[fi]   = 9'(bp);
            hdr_tab[fi]  = hdr;
            loaded[fi]   = 1;
        end
    endtask

    task automatic load_frame(int fi, int fb, int side, int bp, logic [31:0] hdr);
        send_word(1'b0, fi, fb, side, bp, hdr);
    endtask

    task automatic build_frame(int fi);
        send_word(1'b1, fi, 0, 0, 0, 32'd0);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (seg_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_IL_EN)
            il_en = val[0];
        else
            group_size = val;
    endtask

    task automatic set_mode(logic il, logic [7:0] grp, int idle, int stall);
        drain();
        write_reg(CFG_IL_EN, {7'd0, il});
        write_reg(CFG_SPG, grp);
        send_idle_pct = idle;
        stall_pct = stall;
    endtask

    task automatic random_frame(int fi);
        int fb;
        fb = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(1500, 60);
        load_frame(fi, fb, $urandom_range(32),
                   ($urandom_range(3) == 0) ? $urandom_range(511) : $urandom_range(120),
                   $urandom());
    endtask

    task automatic test_directed();
        build_frame(0);
        load_frame(1, 400, 17, 0, 32'hFFFF_FFFF);
        build_frame(1);
        load_frame(2, 4095, 32, 511, 32'h0000_0000);
        build_frame(2);
        load_frame(2, 300, 32, 200, 32'hA5A5_5A5A);
        build_frame(1);
        build_frame(2);
        // saturating sizes and empty data blocks
        load_frame(3, 0, 32, 0, 32'h1234_5678);
        load_frame(4, 36, 32, 50, 32'h8765_4321);
        build_frame(3);
        build_frame(4);
        for (int f = 4086; f <= 4095; f++)
            load_frame(f, 30, 0, 20, $urandom());
        build_frame(4095);
        load_frame(4095, 104, 0, 150, 32'hFFE0_0000);
        build_frame(4095);
    endtask

    task automatic test_random(int items);
        int base, len, cnt, s;
        cnt = 0;
        while (cnt < items)
        begin
            base = ($urandom_range(7) == 0) ? $urandom_range(4095, 4080) : $urandom_range(200, 1);
            len = $urandom_range(12, 1);
            for (int f = base; f < base + len && f < 4096 && cnt < items; f++)
            begin
                random_frame(f);
                cnt++;
            end
            repeat ($urandom_range(6, 1))
            begin
                if ($urandom_range(15) == 0)
                    s = 0;
                else
                    s = $urandom_range(base + len - 1 > 4095 ? 4095 : base + len - 1, base);
                if (s == 0 || can_build(s))
                begin
                    build_frame(s);
                    cnt++;
                end
            end
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        test_random(30);
    endtask

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (out_ch.valid && out_ch.ready)
        begin
            if (seg_q.size() == 0)
            begin
                $error("unexpected word kind=%0d", out_ch.kind);
                errors++;
            end
            else
            begin
                seg_t e;
                e = seg_q.pop_front();
                if (out_ch.kind !== e.kind)
                begin
                    $error("kind exp %0d got %0d", e.kind, out_ch.kind);
                    errors++;
                end
                if (out_ch.header_word !== e.header_word)
                begin
                    $error("header_word exp %h got %h", e.header_word, out_ch.header_word);
                    errors++;
                end
                if (out_ch.source_frame !== e.source_frame)
                begin
                    $error("source_frame exp %0d got %0d", e.source_frame, out_ch.source_frame);
                    errors++;
                end
                if (out_ch.byte_offset !== e.byte_offset)
                begin
                    $error("byte_offset exp %0d got %0d", e.byte_offset, out_ch.byte_offset);
                    errors++;
                end
                if (out_ch.byte_count !== e.byte_count)
                begin
                    $error("byte_count exp %0d got %0d", e.byte_count, out_ch.byte_count);
                    errors++;
                end
                if (out_ch.last !== e.last)
                begin
                    $error("last exp %0d got %0d", e.last, out_ch.last);
                    errors++;
                end
            end
        end
    end

    // the table clear after reset also counts as quiet time
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 20000)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        in_ch.valid           = 1'b0;
        in_ch.cmd             = 1'b0;
        in_ch.frame_index     = '0;
        in_ch.frame_bytes     = '0;
        in_ch.side_info_bytes = '0;
        in_ch.back_pointer    = '0;
        in_ch.frame_header    = '0;
        out_ch.ready          = 1'b0;
        for (int i = 0; i < 4096; i++)
        begin
            bp_tab[i] = '0;
            size_tab[i] = '0;
            side_tab[i] = '0;
            hdr_tab[i] = '0;
            loaded[i] = 0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        set_mode(1'b1, 8'd1, 0, 0);
        test_directed();
        set_mode(1'b0, 8'd1, 0, 0);
        test_random(70);
        set_mode(1'b1, 8'd3, 75, 0);
        test_random(60);
        set_mode(1'b1, 8'd255, 0, 75);
        test_random(60);
        set_mode(1'b1, 8'd0, 36, 36);
        test_random(60);
        set_mode(1'b0, 8'd7, 0, 0);
        test_random(60);
        set_mode(1'b1, 8'd5, 0, 0);
        test_backpressure();
        drain();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

>>> filelist.f
src/mab_pkg.sv
src/mab_if.sv
src/mab_ctrl.sv
src/mab_dp.sv
src/mp3_adu_segment_builder_top.sv
tb/mp3_adu_segment_builder_top_tb.sv
